>>> hw/rtl/ccp_pkg.sv
// Shared constants and types for the checked cubic polynomial core.
`timescale 1ns / 1ps

package ccp_pkg;

  localparam int DATA_W     = 64;
  localparam int HALF_W     = DATA_W / 2;
  localparam int MUL_STAGES = 4;
  localparam int NUM_GROUPS = 3;
  localparam int NUM_STAGES = NUM_GROUPS * MUL_STAGES + 1;
  localparam int CFG_IDX_W  = 2;

  typedef logic [DATA_W-1:0] word_t;

  // Coefficient register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONST  = 2'd0,
    REG_LINEAR = 2'd1,
    REG_SQUARE = 2'd2,
    REG_CUBE   = 2'd3
  } cfg_reg_t;

  // Running sum and sticky range error carried beside the multipliers
  typedef struct packed {
    logic  fail;
    word_t sum;
  } acc_t;

endpackage

>>> hw/rtl/ccp_if.sv
// Valid/ready channel interfaces for samples and results.
`timescale 1ns / 1ps

interface ccp_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] sample_x;

  modport source (output valid, output sample_x, input ready);
  modport sink   (input valid, input sample_x, output ready);
endinterface

interface ccp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] poly_value;
  logic               status;

  modport source (output valid, output poly_value, output status, input ready);
  modport sink   (input valid, input poly_value, input status, output ready);
endinterface

>>> hw/rtl/ccp_mul_chk.sv
// Four-stage signed 64x64 multiplier lanes with overflow check and a sideband.
`timescale 1ns / 1ps

module ccp_mul_chk #(
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                                        clk,
  input  logic [ccp_pkg::MUL_STAGES-1:0]              en,
  input  logic [LANES-1:0][ccp_pkg::DATA_W-1:0]       op_a,
  input  logic [LANES-1:0][ccp_pkg::DATA_W-1:0]       op_b,
  input  logic [SIDE_W-1:0]                           side_in,
  output logic [LANES-1:0][ccp_pkg::DATA_W-1:0]       prod,
  output logic [LANES-1:0]                            ovf,
  output logic [SIDE_W-1:0]                           side_out
);

  localparam int W = ccp_pkg::DATA_W;
  localparam int H = ccp_pkg::HALF_W;

  logic [SIDE_W-1:0] side0_r, side1_r, side2_r, side3_r;

  // Carry the sideband along with the lanes
  always_ff @(posedge clk) begin
    if (en[0]) side0_r <= side_in;
    if (en[1]) side1_r <= side0_r;
    if (en[2]) side2_r <= side1_r;
    if (en[3]) side3_r <= side2_r;
  end

  assign side_out = side3_r;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [W-1:0] ma_r, mb_r;
    logic         neg0_r, neg1_r, neg2_r;
    logic [W-1:0] pl_r, pc_r;
    logic         hi1_r, hi2_r;
    logic [W:0]   s2_r;
    logic [W-1:0] prod_r;
    logic         ovf_r;

    logic [H-1:0] ah, al, bh, bl, xa, xb;
    logic [W-1:0] pl_nxt, pc_nxt;
    logic [W:0]   s2_nxt;
    logic         lim_ovf;

    // Split magnitudes; when both high halves are set the product is too big,
    // otherwise only one cross product can be nonzero
    always_comb begin
      ah     = ma_r[W-1:H];
      al     = ma_r[H-1:0];
      bh     = mb_r[W-1:H];
      bl     = mb_r[H-1:0];
      xa     = (ah == '0) ? al : ah;
      xb     = (ah == '0) ? bh : bl;
      pl_nxt = W'(al) * W'(bl);
      pc_nxt = W'(xa) * W'(xb);
    end

    assign s2_nxt = {1'b0, pl_r} + {1'b0, pc_r[H-1:0], {H{1'b0}}};

    // Negative results may reach 2^63, positive ones stop one short
    assign lim_ovf = neg2_r ? (s2_r[W-1] && (s2_r[W-2:0] != '0)) : s2_r[W-1];

    always_ff @(posedge clk) begin
      // Take magnitudes and result sign
      if (en[0]) begin
        ma_r   <= op_a[l][W-1] ? (W'(0) - op_a[l]) : op_a[l];
        mb_r   <= op_b[l][W-1] ? (W'(0) - op_b[l]) : op_b[l];
        neg0_r <= op_a[l][W-1] ^ op_b[l][W-1];
      end
      // Form the two 32x32 partial products
      if (en[1]) begin
        pl_r   <= pl_nxt;
        pc_r   <= pc_nxt;
        hi1_r  <= (ah != '0) && (bh != '0);
        neg1_r <= neg0_r;
      end
      // Combine into a 65-bit magnitude
      if (en[2]) begin
        s2_r   <= s2_nxt;
        hi2_r  <= hi1_r || (pc_r[W-1:H] != '0);
        neg2_r <= neg1_r;
      end
      // Range check and restore sign
      if (en[3]) begin
        prod_r <= neg2_r ? (W'(0) - s2_r[W-1:0]) : s2_r[W-1:0];
        ovf_r  <= hi2_r || s2_r[W] || lim_ovf;
      end
    end

    assign prod[l] = prod_r;
    assign ovf[l]  = ovf_r;
  end

endmodule

>>> hw/rtl/checked_cubic_polynomial_core.sv
// Top level of the checked cubic polynomial core.
`timescale 1ns / 1ps
//
// Evaluates c0 + c1*x + c2*x^2 + c3*x^3 on signed 64-bit values, one result
// per sample. Samples enter on in_chan, results leave on out_chan; both are
// valid/ready channels and an item moves when valid and ready are both high.
// The four coefficients are written through cfg_we/cfg_idx/cfg_wdata
// (0 const, 1 linear, 2 square, 3 cube) while the core is idle.
// Any product (x*x and x^2*x included) or partial sum that leaves the signed
// 64-bit range gives poly_value 0 with status 1.
// The pipeline is three chained checked multiplies of 4 stages each
// (x^2, x^3, c3*x^3) plus a final add/output register. One sample per cycle
// is accepted in steady state while the receiver keeps ready high.
// Reset clears the coefficients to zero and empties the pipeline.
// When the receiver stalls, items close up behind the output register and
// in_chan.ready drops only once every stage holds an item.

module checked_cubic_polynomial_core (
  input  logic                            clk,
  input  logic                            rst_n,
  ccp_in_if.sink                          in_chan,
  ccp_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [ccp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ccp_pkg::DATA_W-1:0]      cfg_wdata
);

  localparam int W  = ccp_pkg::DATA_W;
  localparam int MS = ccp_pkg::MUL_STAGES;
  localparam int NS = ccp_pkg::NUM_STAGES;
  localparam int AW = $bits(ccp_pkg::acc_t);

  function automatic logic add_ovf(input ccp_pkg::word_t a, input ccp_pkg::word_t b,
                                   input ccp_pkg::word_t s);
    add_ovf = (a[W-1] == b[W-1]) && (s[W-1] != a[W-1]);
  endfunction

  ccp_pkg::word_t c0_r, c1_r, c2_r, c3_r;
  logic [NS-1:0]  v_r;
  logic [NS-1:0]  en;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (cfg_we) begin
      unique case (ccp_pkg::cfg_reg_t'(cfg_idx))
        ccp_pkg::REG_CONST:  c0_r <= cfg_wdata;
        ccp_pkg::REG_LINEAR: c1_r <= cfg_wdata;
        ccp_pkg::REG_SQUARE: c2_r <= cfg_wdata;
        ccp_pkg::REG_CUBE:   c3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_chan.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_chan.ready = en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_chan.valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Group 1: x*x and c1*x
  logic [1:0][W-1:0] g1_a, g1_b, g1_p;
  logic [1:0]        g1_ovf;
  ccp_pkg::word_t    g1_x;

  assign g1_a[0] = in_chan.sample_x;
  assign g1_b[0] = in_chan.sample_x;
  assign g1_a[1] = c1_r;
  assign g1_b[1] = in_chan.sample_x;

  ccp_mul_chk #(.LANES(2), .SIDE_W(W)) u_mul_g1 (
    .clk      (clk),
    .en       (en[MS-1:0]),
    .op_a     (g1_a),
    .op_b     (g1_b),
    .side_in  (in_chan.sample_x),
    .prod     (g1_p),
    .ovf      (g1_ovf),
    .side_out (g1_x)
  );

  // Group 2: x^2*x and c2*x^2, with c0 + c1*x alongside
  logic [1:0][W-1:0] g2_a, g2_b, g2_p;
  logic [1:0]        g2_ovf;
  ccp_pkg::acc_t     g2_in, g2_out;
  ccp_pkg::word_t    sum1;

  assign sum1        = c0_r + g1_p[1];
  assign g2_in.sum   = sum1;
  assign g2_in.fail  = (|g1_ovf) || add_ovf(c0_r, g1_p[1], sum1);
  assign g2_a[0]     = g1_p[0];
  assign g2_b[0]     = g1_x;
  assign g2_a[1]     = c2_r;
  assign g2_b[1]     = g1_p[0];

  ccp_mul_chk #(.LANES(2), .SIDE_W(AW)) u_mul_g2 (
    .clk      (clk),
    .en       (en[2*MS-1:MS]),
    .op_a     (g2_a),
    .op_b     (g2_b),
    .side_in  (g2_in),
    .prod     (g2_p),
    .ovf      (g2_ovf),
    .side_out (g2_out)
  );

  // Group 3: c3*x^3, with the square term added in
  logic [0:0][W-1:0] g3_a, g3_b, g3_p;
  logic [0:0]        g3_ovf;
  ccp_pkg::acc_t     g3_in, g3_out;
  ccp_pkg::word_t    sum2;

  assign sum2       = g2_out.sum + g2_p[1];
  assign g3_in.sum  = sum2;
  assign g3_in.fail = g2_out.fail || (|g2_ovf) || add_ovf(g2_out.sum, g2_p[1], sum2);
  assign g3_a[0]    = c3_r;
  assign g3_b[0]    = g2_p[0];

  ccp_mul_chk #(.LANES(1), .SIDE_W(AW)) u_mul_g3 (
    .clk      (clk),
    .en       (en[3*MS-1:2*MS]),
    .op_a     (g3_a),
    .op_b     (g3_b),
    .side_in  (g3_in),
    .prod     (g3_p),
    .ovf      (g3_ovf),
    .side_out (g3_out)
  );

  // Final add and output register
  ccp_pkg::word_t sum3;
  logic           fail3;
  ccp_pkg::word_t out_val_r;
  logic           out_st_r;

  assign sum3  = g3_out.sum + g3_p[0];
  assign fail3 = g3_out.fail || g3_ovf[0] || add_ovf(g3_out.sum, g3_p[0], sum3);

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_val_r <= fail3 ? '0 : sum3;
      out_st_r  <= fail3;
    end
  end

  assign out_chan.valid      = v_r[NS-1];
  assign out_chan.poly_value = out_val_r;
  assign out_chan.status     = out_st_r;

  // An empty output stage lets every stage advance, so the input is ready
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NS-1] |-> in_chan.ready)
    else $error("input not ready with empty output stage");

  // A range error always comes with a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status) |-> (out_chan.poly_value == '0))
    else $error("range error with nonzero value");

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

  // A blocked middle stage keeps its item
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[MS] && !en[MS]) |=> v_r[MS])
    else $error("stalled item dropped");

endmodule

>>> tb/tb_checked_cubic_polynomial_core.sv
// Self-checking testbench for the checked cubic polynomial core.
`timescale 1ns / 1ps

module tb_checked_cubic_polynomial_core;

  localparam ccp_pkg::word_t S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam ccp_pkg::word_t S64_MIN = 64'h8000_0000_0000_0000;
  localparam ccp_pkg::word_t S64_ONE = 64'd1;
  localparam ccp_pkg::word_t S64_M1  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam bit    ST_OK     = 1'b0;
  localparam bit    ST_RANGE  = 1'b1;
  localparam int    RAND_ITEMS  = 1400;
  localparam int    PHASE_ITEMS = 140;
  localparam int    IDLE_PCT    = 8;
  localparam int    MAX_REPORTS = 10;

  typedef struct {
    ccp_pkg::word_t value;
    bit             status;
  } poly_result_t;

  typedef enum {ROW_COEFS, ROW_SAMPLE} row_kind_t;

  // One directed row: a coefficient set or a sample, optionally with a known result
  typedef struct {
    row_kind_t      kind;
    ccp_pkg::word_t v0;
    ccp_pkg::word_t v1;
    ccp_pkg::word_t v2;
    ccp_pkg::word_t v3;
    bit             known;
    ccp_pkg::word_t want_value;
    bit             want_status;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ccp_pkg::CFG_IDX_W-1:0] cfg_idx;
  ccp_pkg::word_t                cfg_wdata;
  logic                          res_ready = 1'b0;

  ccp_in_if  in_if ();
  ccp_out_if out_if ();

  assign out_if.ready = res_ready;

  ccp_pkg::word_t coef_q [4];
  poly_result_t   pending_q [$];
  stim_row_t      dir_rows [$];
  bit             no_idle;
  int             fault_count;
  int             results_seen;
  int             range_seen;
  int             settings_seen;
  int             samples_sent;

  checked_cubic_polynomial_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Signed 64-bit multiply; returns 1 when the true product fits
  function automatic bit mul_fits(input ccp_pkg::word_t a, input ccp_pkg::word_t b,
                                  output ccp_pkg::word_t prod);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] wp;
    wa = $signed(a);
    wb = $signed(b);
    wp = wa * wb;
    prod = wp[63:0];
    return (wp[127:63] == '0) || (wp[127:63] == '1);
  endfunction

  // Signed 64-bit add; returns 1 when the true sum fits
  function automatic bit add_fits(input ccp_pkg::word_t a, input ccp_pkg::word_t b,
                                  output ccp_pkg::word_t total);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    total = s[63:0];
    return s[64] == s[63];
  endfunction

  // Evaluate the cubic at x with the current coefficients, every step range-checked
  function automatic poly_result_t cubic_value(input ccp_pkg::word_t x);
    ccp_pkg::word_t acc;
    ccp_pkg::word_t term;
    ccp_pkg::word_t x_sq;
    ccp_pkg::word_t x_cu;
    bit             fits;
    poly_result_t   r;
    fits = mul_fits(coef_q[ccp_pkg::REG_LINEAR], x, term);
    fits &= add_fits(coef_q[ccp_pkg::REG_CONST], term, acc);
    fits &= mul_fits(x, x, x_sq);
    fits &= mul_fits(coef_q[ccp_pkg::REG_SQUARE], x_sq, term);
    fits &= add_fits(acc, term, acc);
    fits &= mul_fits(x_sq, x, x_cu);
    fits &= mul_fits(coef_q[ccp_pkg::REG_CUBE], x_cu, term);
    fits &= add_fits(acc, term, acc);
    r.value  = fits ? acc : '0;
    r.status = fits ? ST_OK : ST_RANGE;
    return r;
  endfunction

  function automatic ccp_pkg::word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random magnitude of up to max_bits bits, random sign
  function automatic ccp_pkg::word_t rand_span(input int max_bits);
    int             bits;
    ccp_pkg::word_t mag;
    bits = $urandom_range(1, max_bits);
    mag  = rand_word() >> (64 - bits);
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  function automatic ccp_pkg::word_t rand_extreme();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return S64_ONE;
      2: return S64_M1;
      3: return S64_MAX;
      default: return S64_MIN;
    endcase
  endfunction

  function automatic ccp_pkg::word_t rand_coef();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return rand_span(10);
      5, 6:    return rand_span(32);
      7:       return rand_span(62);
      8:       return rand_extreme();
      default: return rand_word();
    endcase
  endfunction

  // Samples lean toward small values and the square/cube range edges
  function automatic ccp_pkg::word_t rand_sample();
    ccp_pkg::word_t base;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return rand_span(12);
      6, 7, 8, 9, 10:   return rand_span(22);
      11, 12: begin
        case ($urandom_range(0, 3))
          0: base = 64'd2097151;
          1: base = 64'd2097152;
          2: base = 64'd3037000499;
          default: base = 64'd3037000500;
        endcase
        base = base + 64'($urandom_range(0, 2)) - 64'd1;
        return ($urandom_range(0, 1) != 0) ? -base : base;
      end
      13, 14, 15: return rand_span(64);
      16, 17:     return rand_word();
      default:    return rand_extreme();
    endcase
  endfunction

  function automatic void add_coefs(input ccp_pkg::word_t c0, input ccp_pkg::word_t c1,
                                    input ccp_pkg::word_t c2, input ccp_pkg::word_t c3);
    dir_rows.push_back('{ROW_COEFS, c0, c1, c2, c3, 1'b0, '0, ST_OK});
  endfunction

  function automatic void add_sample(input ccp_pkg::word_t x);
    dir_rows.push_back('{ROW_SAMPLE, x, '0, '0, '0, 1'b0, '0, ST_OK});
  endfunction

  function automatic void add_known(input ccp_pkg::word_t x, input ccp_pkg::word_t value,
                                    input bit status);
    dir_rows.push_back('{ROW_SAMPLE, x, '0, '0, '0, 1'b1, value, status});
  endfunction

  // Drop valid and wait until every result is back and the pipe is empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (ccp_pkg::NUM_STAGES + 2) @(negedge clk);
  endtask

  // Load all four coefficients while the core is idle
  task automatic write_coefs(input ccp_pkg::word_t c0, input ccp_pkg::word_t c1,
                             input ccp_pkg::word_t c2, input ccp_pkg::word_t c3);
    ccp_pkg::word_t vals [4];
    vals = '{c0, c1, c2, c3};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= ccp_pkg::cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      coef_q[i] = vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic send_sample(input ccp_pkg::word_t x, input bit known,
                             input poly_result_t want);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.sample_x <= x;
    do @(posedge clk); while (!in_if.ready);
    pending_q.push_back(known ? want : cubic_value(x));
    samples_sent++;
    @(negedge clk);
  endtask

  // Result-side backpressure
  always @(negedge clk) begin
    res_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    poly_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: value %h status %0b",
                   $realtime, out_if.poly_value, out_if.status);
      end else begin
        want = pending_q.pop_front();
        results_seen++;
        if (want.status == ST_RANGE) range_seen++;
        if (out_if.poly_value !== want.value || out_if.status !== want.status) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("[%0t] result %0d mismatch: expected value %h status %0b, got %h %0b",
                     $realtime, results_seen, want.value, want.status,
                     out_if.poly_value, out_if.status);
        end
      end
    end
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    poly_result_t no_want;
    int           phase;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = ccp_pkg::REG_CONST;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.sample_x = '0;
    no_idle        = 1'b0;
    no_want        = '{'0, ST_OK};
    fault_count    = 0;
    results_seen   = 0;
    range_seen     = 0;
    settings_seen  = 0;
    samples_sent   = 0;
    foreach (coef_q[i]) coef_q[i] = '0;

    // Directed rows: reset coefficients first, unused powers still range-checked
    add_known('0, '0, ST_OK);
    add_known(S64_MAX, '0, ST_RANGE);
    add_known(S64_MIN, '0, ST_RANGE);
    add_known(S64_ONE, '0, ST_OK);
    add_known(64'd3037000499, '0, ST_RANGE);
    add_known(-64'd2097152, '0, ST_OK);
    add_known(64'd2097152, '0, ST_RANGE);
    // Constant at the top, linear term pushes over
    add_coefs(S64_MAX, S64_ONE, '0, '0);
    add_known('0, S64_MAX, ST_OK);
    add_known(S64_ONE, '0, ST_RANGE);
    add_known(S64_M1, 64'h7FFF_FFFF_FFFF_FFFE, ST_OK);
    // Constant at the bottom
    add_coefs(S64_MIN, S64_M1, '0, '0);
    add_known(S64_ONE, '0, ST_RANGE);
    add_known(S64_M1, 64'h8000_0000_0000_0001, ST_OK);
    // Most negative cube coefficient
    add_coefs('0, '0, '0, S64_MIN);
    add_known(S64_ONE, S64_MIN, ST_OK);
    add_known(S64_M1, '0, ST_RANGE);
    add_coefs('0, S64_MAX, '0, '0);
    add_known(S64_M1, 64'h8000_0000_0000_0001, ST_OK);
    add_known(64'd2, '0, ST_RANGE);
    // Small mixed-sign coefficients
    add_coefs(-64'd3, 64'd5, -64'd7, 64'd11);
    add_sample(64'd3);
    add_sample(-64'd2097151);
    add_sample(64'd1000);
    add_coefs(S64_MAX, S64_MAX, S64_MAX, S64_MAX);
    add_known('0, S64_MAX, ST_OK);
    add_known(S64_ONE, '0, ST_RANGE);
    // Square only: cube power still checked
    add_coefs('0, '0, S64_ONE, '0);
    add_known(64'd3037000499, '0, ST_RANGE);
    add_sample(-64'd2097152);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_COEFS) begin
        write_coefs(dir_rows[i].v0, dir_rows[i].v1, dir_rows[i].v2, dir_rows[i].v3);
      end else begin
        send_sample(dir_rows[i].v0, dir_rows[i].known,
                    '{dir_rows[i].want_value, dir_rows[i].want_status});
      end
    end

    // Random phases, fresh coefficients each; one phase runs without any idling
    phase = 0;
    while (samples_sent < RAND_ITEMS + dir_rows.size()) begin
      write_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
      no_idle = (phase == 3);
      repeat (PHASE_ITEMS) send_sample(rand_sample(), 1'b0, no_want);
      phase++;
    end
    no_idle = 1'b0;

    settle();
    if (pending_q.size() != 0) begin
      fault_count += pending_q.size();
      $display("%0d expected results never arrived", pending_q.size());
    end

    $display("Sent %0d samples under %0d coefficient sets.", samples_sent, settings_seen);
    $display("Checked %0d results, %0d of them range errors; %0d faults.",
             results_seen, range_seen, fault_count);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
